// File: design/circle_outline_pixel_writer_macros.svh
// assertion macros for the circle outline pixel writer
// used by design/circle_outline_pixel_writer.sv; assumes clk and rst_n in scope
`ifndef CIRCLE_OUTLINE_PIXEL_WRITER_MACROS_SVH
`define CIRCLE_OUTLINE_PIXEL_WRITER_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define CPW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("circle writer check failed");
// condition that must never be true outside reset
`define CPW_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("circle writer forbidden condition");
`else
`define CPW_ASSERT(lbl, prop)
`define CPW_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: design/cpw_pkg.sv
// shared types and constants for the circle outline pixel writer
// no dependencies; used by circle_outline_pixel_writer
`timescale 1ns / 1ps
package cpw_pkg;

    // frame buffer geometry in pixels, two bytes per pixel
    localparam int unsigned WIDTH  = 96;
    localparam int unsigned HEIGHT = 64;
    localparam int unsigned FB_LIMIT    = WIDTH * HEIGHT * 2;
    localparam int unsigned ROW_STRIDE  = WIDTH * 2;

    // input item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // configuration register indexes
    localparam logic CFG_PIXEL_COLOUR = 1'b0;
    localparam logic CFG_DRAW_MODE    = 1'b1;

    // draw mode codes
    localparam logic MODE_CLEAR = 1'b0;
    localparam logic MODE_SET   = 1'b1;

    typedef struct packed {
        logic              kind;
        logic signed [7:0] center_x;
        logic signed [7:0] center_y;
        logic [6:0]        radius;
    } in_item_t;

    typedef struct packed {
        logic [15:0] byte_address;
        logic [15:0] pixel_word;
        logic        write_enable;
        logic        last;
    } out_item_t;

    // one step's worth of points waiting to be emitted
    typedef struct packed {
        logic [7:0]        centre_first;
        logic [7:0]        centre_second;
        logic signed [8:0] offset_x;
        logic signed [8:0] offset_y;
        logic              last;
    } job_t;

endpackage

// File: design/circle_outline_pixel_writer.sv
// circle outline rasteriser producing frame buffer pixel writes
// depends on cpw_pkg and circle_outline_pixel_writer_macros.svh
`timescale 1ns / 1ps
`include "circle_outline_pixel_writer_macros.svh"

// A start item (kind 0) loads centre and radius and gives no result. Each
// step item (kind 1) while a circle is running runs one midpoint iteration
// and gives four pixel writes, one per cycle on the result channel while
// out_stall is low, paced by the single result port; a step is taken while
// the previous step's last points still drain. The first write of a step
// passes through the pending step register and then the output register
// before it is offered on the result port. Steps while no circle is running
// are taken and dropped. Configuration is always ready.
module circle_outline_pixel_writer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cpw_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output cpw_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    // configuration registers
    logic [15:0] pixel_colour_reg;
    logic        draw_mode_reg;

    // circle state
    logic              active_reg,        active_next;
    logic [7:0]        centre_first_reg,  centre_first_next;
    logic [7:0]        centre_second_reg, centre_second_next;
    logic signed [8:0] offset_x_reg,      offset_x_next;
    logic signed [8:0] offset_y_reg,      offset_y_next;
    logic signed [15:0] error_term_reg,   error_term_next;

    // pending step and output stage
    logic               job_valid_reg, job_valid_next;
    cpw_pkg::job_t      job_reg,       job_next;
    logic [1:0]         count_reg,     count_next;
    logic               out_valid_reg, out_valid_next;
    cpw_pkg::out_item_t out_reg,       out_next;

    logic in_take;
    logic is_step;
    logic out_free;
    logic out_load;
    logic job_done;
    logic job_take;

    // iteration datapath
    logic signed [15:0] x16, y16, y1_16, x1_16;
    logic signed [15:0] e2_mod, err_a, err_b;
    logic               grow_y, grow_x, step_done;

    // point datapath
    logic [7:0]  dx, dy, first, second;
    logic [15:0] addr;

    assign cfg_ready = 1'b1;

    // configuration transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_colour_reg <= '0;
            draw_mode_reg    <= cpw_pkg::MODE_SET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cpw_pkg::CFG_PIXEL_COLOUR: pixel_colour_reg <= cfg_data;
                cpw_pkg::CFG_DRAW_MODE:    draw_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = job_valid_reg && out_free;
    assign job_done = out_load && (count_reg == 2'd3);
    assign in_stall = job_valid_reg && !job_done;
    assign in_take  = in_valid && !in_stall;
    assign is_step  = (in_item.kind == cpw_pkg::KIND_STEP);
    assign job_take = in_take && is_step && active_reg;

    // one midpoint iteration
    always_comb
    begin
        x16   = 16'(offset_x_reg);
        y16   = 16'(offset_y_reg);
        grow_y = (error_term_reg <= y16);
        y1_16 = grow_y ? y16 + 16'sd1 : y16;
        err_a = grow_y ? error_term_reg + (y1_16 <<< 1) + 16'sd1 : error_term_reg;
        e2_mod = (grow_y && (-x16 == y1_16) && (error_term_reg <= x16))
                 ? 16'sd0 : error_term_reg;
        grow_x = (e2_mod > x16);
        x1_16 = grow_x ? x16 + 16'sd1 : x16;
        err_b = grow_x ? err_a + (x1_16 <<< 1) + 16'sd1 : err_a;
        step_done = (x1_16 > 16'sd0);
    end

    // circle state next values
    always_comb
    begin
        active_next        = active_reg;
        centre_first_next  = centre_first_reg;
        centre_second_next = centre_second_reg;
        offset_x_next      = offset_x_reg;
        offset_y_next      = offset_y_reg;
        error_term_next    = error_term_reg;
        if (in_take && !is_step)
        begin
            active_next        = 1'b1;
            centre_first_next  = in_item.center_x;
            centre_second_next = in_item.center_y;
            offset_x_next      = -$signed({2'b00, in_item.radius});
            offset_y_next      = '0;
            error_term_next    = 16'sd2 - $signed({8'd0, in_item.radius, 1'b0});
        end
        else if (job_take)
        begin
            offset_x_next   = x1_16[8:0];
            offset_y_next   = y1_16[8:0];
            error_term_next = err_b;
            if (step_done)
                active_next = 1'b0;
        end
    end

    // pending step and counter
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        count_next     = count_reg;
        if (out_load)
            count_next = count_reg + 2'd1;
        if (job_done)
            job_valid_next = 1'b0;
        if (job_take)
        begin
            job_valid_next         = 1'b1;
            count_next             = 2'd0;
            job_next.centre_first  = centre_first_reg;
            job_next.centre_second = centre_second_reg;
            job_next.offset_x      = offset_x_reg;
            job_next.offset_y      = offset_y_reg;
            job_next.last          = step_done;
        end
    end

    // mirrored point for the current count
    always_comb
    begin
        case (count_reg)
            2'd0:
            begin
                dx = -job_reg.offset_x[7:0];
                dy = job_reg.offset_y[7:0];
            end
            2'd1:
            begin
                dx = job_reg.offset_x[7:0];
                dy = job_reg.offset_y[7:0];
            end
            2'd2:
            begin
                dx = job_reg.offset_x[7:0];
                dy = -job_reg.offset_y[7:0];
            end
            default:
            begin
                dx = -job_reg.offset_x[7:0];
                dy = -job_reg.offset_y[7:0];
            end
        endcase
        first  = job_reg.centre_first + dx;
        second = job_reg.centre_second + dy;
        addr   = {7'd0, first, 1'b0} + 16'(32'(second) * cpw_pkg::ROW_STRIDE);
    end

    // output stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
            out_valid_next = out_load;
        if (out_load)
        begin
            out_next.byte_address = addr;
            out_next.pixel_word   = (draw_mode_reg == cpw_pkg::MODE_SET)
                                    ? pixel_colour_reg : 16'd0;
            out_next.write_enable = (17'(addr) < 17'(cpw_pkg::FB_LIMIT));
            out_next.last         = job_reg.last && (count_reg == 2'd3);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg        <= 1'b0;
            centre_first_reg  <= '0;
            centre_second_reg <= '0;
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            error_term_reg    <= '0;
            job_valid_reg     <= 1'b0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            active_reg        <= active_next;
            centre_first_reg  <= centre_first_next;
            centre_second_reg <= centre_second_next;
            offset_x_reg      <= offset_x_next;
            offset_y_reg      <= offset_y_next;
            error_term_reg    <= error_term_next;
            job_valid_reg     <= job_valid_next;
            count_reg         <= count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // checks
    `CPW_ASSERT(a_stall_needs_job, in_stall |-> job_valid_reg)
    `CPW_ASSERT(a_new_job_count, job_take |=> (count_reg == 2'd0) && job_valid_reg)
    `CPW_ASSERT(a_last_on_fourth, (out_load && count_reg != 2'd3) |=> !out_reg.last)
    `CPW_ASSERT(a_active_holds, (job_take && !step_done) |=> active_reg)

endmodule

// File: tb/cpw_circle_checker.sv
// pixel write checker for the circle outline pixel writer: watches all three channels
// keeps its own circle tracer and colour registers, needs cpw_pkg
`timescale 1ns / 1ps

module cpw_circle_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  cpw_pkg::in_item_t  in_item,
    input  logic               out_valid,
    input  logic               out_stall,
    input  cpw_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 outstanding
);

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the configuration registers
    logic [15:0]       colour_reg;
    logic              mode_reg;

    // tracer state of the circle being drawn
    logic              tracing;
    logic [7:0]        ctr_col;
    logic [7:0]        ctr_row;
    logic signed [8:0] off_x;
    logic signed [8:0] off_y;
    logic signed [15:0] err_acc;

    // pixel writes predicted but not yet seen
    cpw_pkg::out_item_t pixel_q[$];

    // one mirrored point as a frame buffer write
    function automatic cpw_pkg::out_item_t plot_point(input int dx, input int dy,
                                                      input logic is_last);
        logic [7:0]         px;
        logic [7:0]         py;
        logic [15:0]        addr;
        cpw_pkg::out_item_t p;
        px   = ctr_col + dx[7:0];
        py   = ctr_row + dy[7:0];
        addr = 16'(int'(px) * 2 + int'(py) * int'(cpw_pkg::ROW_STRIDE));
        p.byte_address = addr;
        p.pixel_word   = (mode_reg == cpw_pkg::MODE_SET) ? colour_reg : 16'h0000;
        p.write_enable = (int'(addr) < int'(cpw_pkg::FB_LIMIT));
        p.last         = is_last;
        return p;
    endfunction

    // one midpoint iteration: queue four points, then move the offsets on
    function automatic void trace_iteration();
        int   x;
        int   y;
        int   e;
        int   e2;
        int   ox;
        int   oy;
        logic done;
        ox = off_x;
        oy = off_y;
        x  = ox;
        y  = oy;
        e  = err_acc;
        e2 = e;
        if (e2 <= y)
        begin
            y++;
            e += y * 2 + 1;
            if (-x == y && e2 <= x)
                e2 = 0;
        end
        if (e2 > x)
        begin
            x++;
            e += x * 2 + 1;
        end
        done = (x > 0);
        pixel_q.push_back(plot_point(-ox, oy, 1'b0));
        pixel_q.push_back(plot_point(ox, oy, 1'b0));
        pixel_q.push_back(plot_point(ox, -oy, 1'b0));
        pixel_q.push_back(plot_point(-ox, -oy, done));
        off_x   = 9'(x);
        off_y   = 9'(y);
        err_acc = 16'(e);
        if (done)
            tracing = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cpw_pkg::out_item_t want;
        if (!rst_n)
        begin
            colour_reg = 16'h0000;
            mode_reg   = cpw_pkg::MODE_SET;
            tracing    = 1'b0;
            ctr_col    = 8'h00;
            ctr_row    = 8'h00;
            off_x      = '0;
            off_y      = '0;
            err_acc    = '0;
            pixel_q.delete();
            fail_count = 0;
        end
        else
        begin
            // register write transfer
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == cpw_pkg::CFG_PIXEL_COLOUR)
                    colour_reg = cfg_data;
                else
                    mode_reg = cfg_data[0];
            end

            // result transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pixel_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected pixel write addr %h word %h we %b last %b",
                                 $time, out_item.byte_address, out_item.pixel_word,
                                 out_item.write_enable, out_item.last);
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (out_item.byte_address !== want.byte_address ||
                        out_item.pixel_word !== want.pixel_word ||
                        out_item.write_enable !== want.write_enable ||
                        out_item.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $write("%0t: pixel write expected addr %h word %h we %b last %b,",
                                   $time, want.byte_address, want.pixel_word,
                                   want.write_enable, want.last);
                            $display(" got addr %h word %h we %b last %b",
                                     out_item.byte_address, out_item.pixel_word,
                                     out_item.write_enable, out_item.last);
                        end
                    end
                end
            end

            // input transfer: load a circle or trace one iteration
            if (in_valid && !in_stall)
            begin
                if (in_item.kind == cpw_pkg::KIND_START)
                begin
                    ctr_col = in_item.center_x;
                    ctr_row = in_item.center_y;
                    off_x   = -$signed({2'b00, in_item.radius});
                    off_y   = '0;
                    err_acc = 16'(2 - 2 * int'(in_item.radius));
                    tracing = 1'b1;
                end
                else if (tracing)
                    trace_iteration();
            end
        end
        outstanding = pixel_q.size();
    end

endmodule

// File: tb/tb_top.sv
// testbench top for the circle outline pixel writer: stimulus, stall patterns and verdict
// depends on cpw_pkg, circle_outline_pixel_writer and cpw_circle_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int WORK_TARGET = 210;
    localparam int HOLD_CYCLES = 150;
    localparam int QUIET_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    cpw_pkg::in_item_t  in_item = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    cpw_pkg::out_item_t out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = cpw_pkg::CFG_PIXEL_COLOUR;
    logic [15:0]        cfg_data = 16'h0000;

    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;
    int          work_items = 0;
    int          burst_left = 1;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          stall_tick = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    circle_outline_pixel_writer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cpw_circle_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls: a long hold-off on request, otherwise changing patterns
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 64);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= (stall_tick % 3 == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // offer one item and hold it until the transfer; bursts end in a gap
    task automatic send_item(input logic knd, input logic [7:0] cx, input logic [7:0] cy,
                             input logic [6:0] r);
        cpw_pkg::in_item_t it;
        logic              taken;
        it.kind     = knd;
        it.center_x = cx;
        it.center_y = cy;
        it.radius   = r;
        in_item  <= it;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 8);
        end
    endtask

    task automatic send_step();
        send_item(cpw_pkg::KIND_STEP, 8'($urandom), 8'($urandom), 7'($urandom));
    endtask

    // start a circle and advance it a number of iterations
    task automatic draw_circle(input logic [7:0] cx, input logic [7:0] cy, input logic [6:0] r,
                               input int n_steps);
        send_item(cpw_pkg::KIND_START, cx, cy, r);
        repeat (n_steps) send_step();
        work_items += 1 + ((n_steps < 2 * int'(r) + 1) ? n_steps : 2 * int'(r) + 1);
    endtask

    // stop offering and wait until every predicted write has been seen
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        do @(negedge clk); while (outstanding != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        logic taken;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] colour, input logic mode);
        wait_drain();
        write_reg(cpw_pkg::CFG_PIXEL_COLOUR, colour);
        write_reg(cpw_pkg::CFG_DRAW_MODE, {15'd0, mode});
    endtask

    // centre mostly inside the frame buffer, sometimes anywhere
    task automatic pick_centre(output logic [7:0] cx, output logic [7:0] cy);
        if ($urandom_range(0, 9) < 7)
        begin
            cx = 8'($urandom_range(0, cpw_pkg::WIDTH - 1));
            cy = 8'($urandom_range(0, cpw_pkg::HEIGHT - 1));
        end
        else
        begin
            cx = 8'($urandom);
            cy = 8'($urandom);
        end
    endtask

    initial
    begin
        logic [7:0] cx;
        logic [7:0] cy;
        logic [6:0] r;
        int         pick;
        int         cfg_phase;
        int         next_cfg_at;
        bit         held;
        bit         paused;

        cfg_phase   = 0;
        next_cfg_at = 70;
        held        = 1'b0;
        paused      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: step while idle, zero radius with reset colour registers
        send_step();
        draw_circle(8'h00, 8'h00, 7'd0, 2);
        set_config(16'hFFFF, cpw_pkg::MODE_SET);
        // centre at the signed extremes, points outside the buffer
        draw_circle(8'h80, 8'h7F, 7'd5, 3);
        // largest radius, abandoned by a fresh start
        draw_circle(8'h7F, 8'h80, 7'd127, 2);
        draw_circle(8'd10, 8'd10, 7'd1, 4);
        // coordinates wrapping through zero
        draw_circle(8'hFF, 8'hFF, 7'd3, 8);
        set_config(16'h0000, cpw_pkg::MODE_CLEAR);
        draw_circle(8'd48, 8'd32, 7'd2, 6);

        // random circles, broken sequences and noise
        while (work_items < WORK_TARGET)
        begin
            if (work_items >= next_cfg_at)
            begin
                case (cfg_phase % 4)
                    0: set_config(16'($urandom), cpw_pkg::MODE_SET);
                    1: set_config(16'hFFFF, cpw_pkg::MODE_CLEAR);
                    2: set_config(16'h0000, cpw_pkg::MODE_SET);
                    default: set_config(16'($urandom), 1'($urandom_range(0, 1)));
                endcase
                cfg_phase++;
                next_cfg_at += 40;
            end

            // receiver holds off while steps keep coming
            if (!held && work_items >= 90)
            begin
                held = 1'b1;
                hold_requests++;
                pick_centre(cx, cy);
                draw_circle(cx, cy, 7'd10, 22);
            end
            // sender waits for every write to land
            if (!paused && work_items >= 150)
            begin
                paused = 1'b1;
                wait_drain();
            end

            pick = $urandom_range(0, 99);
            pick_centre(cx, cy);
            if (pick < 70)
            begin
                if ($urandom_range(0, 9) < 8)
                    r = 7'($urandom_range(0, 8));
                else
                    r = 7'($urandom_range(9, 24));
                draw_circle(cx, cy, r, 2 * int'(r) + 1 + $urandom_range(0, 1));
            end
            else if (pick < 85)
            begin
                r = 7'($urandom_range(0, 127));
                draw_circle(cx, cy, r, $urandom_range(0, (r < 10) ? int'(r) : 10));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(1'($urandom), 8'($urandom), 8'($urandom), 7'($urandom));
                    work_items++;
                end
            end
        end

        wait_drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
